>>> design/pmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the position loop motor drive
// ----------------------------------------------------------------------------
package pmd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgPropGain   = 3'd0,
    CfgIntGain    = 3'd1,
    CfgDerivGain  = 3'd2,
    CfgTolerance  = 3'd3,
    CfgSamplePer  = 3'd4
  } pmd_cfg_idx_e;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned GainW     = 32;
  localparam int unsigned ErrW      = 32;
  localparam int unsigned SumW      = 48;
  localparam int unsigned DriveW    = 18;
  localparam int unsigned ChunkW    = 16;
  localparam int unsigned AccW      = 80;
  localparam int unsigned TermMagW  = 61;
  localparam int unsigned CmpW      = 7;

  // +-1.0 in q2.16
  localparam logic [DriveW-1:0] DrivePosOne = 18'h10000;
  localparam logic [DriveW-1:0] DriveNegOne = 18'h30000;
  localparam logic [TermMagW-1:0] TermLimit = {1'b1, 60'd0};

  // control for the shared multiply-accumulate unit
  typedef struct packed {
    logic       clr;
    logic       mul;
    logic       acc;
    logic [1:0] idx;
  } pmd_mul_ctrl_t;

endpackage

>>> design/pid_position_motor_drive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_motor_drive_unit
// One axis position loop: pid controller driving a sign-magnitude pwm compare
// sequence: a start or a tick without update goes straight to the result state,
//   a finishing sample through the error state, a full pid update through error,
//   integral, the three gain products, clamp and result; one item at a time; the
//   gain products pass through one 32x16 multiplier in three digits each
// reset: asynchronous, active low; state cleared, tolerance 10, sample period 1
// ----------------------------------------------------------------------------
module pid_position_motor_drive_unit
  import pmd_pkg::*;
#(
  parameter int unsigned FULL_SCALE = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // encoder_delta[15:0], target[47:16]
  input  logic                s_axis_tuser,  // cmd
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata   // compare_value[6:0], direction[7],
                                             // running[8], finished[9], zero
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StErr    = 3'd1;
  localparam logic [2:0] StInteg  = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StAcc    = 3'd4;
  localparam logic [2:0] StTerm   = 3'd5;
  localparam logic [2:0] StClamp  = 3'd6;
  localparam logic [2:0] StResult = 3'd7;

  // configuration
  logic [GainW-1:0] kp_q, ki_q, kd_q;
  logic [15:0]      tol_q, period_q;

  // loop state
  logic [2:0]        state_q, state_d;
  logic [31:0]       pos_q, pos_d;
  logic [31:0]       goal_q, goal_d;
  logic [15:0]       tick_q, tick_d;
  logic [SumW-1:0]   esum_q, esum_d;
  logic [ErrW-1:0]   last_q, last_d;
  logic [DriveW-1:0] drive_q, drive_d;
  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [ErrW-1:0]   err_q, err_d;
  logic [32:0]       diff_q, diff_d;
  logic [63:0]       sum_q, sum_d;
  logic [1:0]        term_q, term_d;
  logic [1:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [9:0]        out_data_q, out_data_d;

  logic              accept;
  logic [15:0]       tick_inc;
  logic [32:0]       err_wide;
  logic [ErrW-1:0]   err_sat;
  logic [ErrW-1:0]   err_mag;
  logic [SumW:0]     esum_wide;
  logic [SumW-1:0]   esum_sat;
  logic [SumW-1:0]   esum_mag;
  logic [32:0]       diff_mag;
  logic [GainW-1:0]  a_mag;
  logic [SumW-1:0]   b_mag;
  logic              term_neg;
  logic [TermMagW-1:0] sat_mag;
  logic [63:0]       term_val;
  logic [CmpW-1:0]   cmp_val;
  logic              dir_val;
  pmd_mul_ctrl_t     mul_ctrl;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      tol_q    <= 16'd10;
      period_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (pmd_cfg_idx_e'(cfg_addr_i))
        CfgPropGain:  kp_q     <= cfg_data_i;
        CfgIntGain:   ki_q     <= cfg_data_i;
        CfgDerivGain: kd_q     <= cfg_data_i;
        CfgTolerance: tol_q    <= cfg_data_i[15:0];
        CfgSamplePer: period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // error and integral arithmetic
  assign tick_inc = tick_q + 16'd1;
  assign err_wide = {goal_q[31], goal_q} - {pos_q[31], pos_q};
  assign err_sat  = (err_wide[32] != err_wide[31])
                    ? (err_wide[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                    : err_wide[31:0];
  assign err_mag  = err_sat[31] ? -err_sat : err_sat;

  assign esum_wide = {esum_q[SumW-1], esum_q} + {{(SumW-ErrW+1){err_q[31]}}, err_q};
  assign esum_sat  = (esum_wide[SumW] != esum_wide[SumW-1])
                     ? (esum_wide[SumW] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                     : esum_wide[SumW-1:0];
  assign esum_mag  = esum_q[SumW-1] ? -esum_q : esum_q;
  assign diff_mag  = diff_q[32] ? -diff_q : diff_q;

  // operands of the shared unit for the current term
  always_comb begin
    case (term_q)
      2'd0: begin
        a_mag    = kp_q[31] ? -kp_q : kp_q;
        b_mag    = {16'd0, err_q[31] ? -err_q : err_q};
        term_neg = kp_q[31] ^ err_q[31];
      end
      2'd1: begin
        a_mag    = ki_q[31] ? -ki_q : ki_q;
        b_mag    = esum_mag;
        term_neg = ki_q[31] ^ esum_q[SumW-1];
      end
      2'd2: begin
        a_mag    = kd_q[31] ? -kd_q : kd_q;
        b_mag    = {15'd0, diff_mag};
        term_neg = kd_q[31] ^ diff_q[32];
      end
      default: begin
        a_mag    = '0;
        b_mag    = '0;
        term_neg = 1'b0;
      end
    endcase
  end

  assign term_val = term_neg ? -{3'd0, sat_mag} : {3'd0, sat_mag};

  pmd_mul_unit u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .a_mag_i   (a_mag),
    .b_mag_i   (b_mag),
    .sat_mag_o (sat_mag)
  );

  pmd_pwm_map #(
    .FULL_SCALE (FULL_SCALE)
  ) u_pwm (
    .drive_i     (drive_q),
    .compare_o   (cmp_val),
    .direction_o (dir_val)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    goal_d      = goal_q;
    tick_d      = tick_q;
    esum_d      = esum_q;
    last_d      = last_q;
    drive_d     = drive_q;
    active_d    = active_q;
    done_d      = done_q;
    err_d       = err_q;
    diff_d      = diff_q;
    sum_d       = sum_q;
    term_d      = term_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_ctrl    = '{clr: 1'b0, mul: 1'b0, acc: 1'b0, idx: idx_q};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StResult;
          if (s_axis_tuser) begin
            goal_d   = s_axis_tdata[47:16];
            active_d = 1'b1;
            done_d   = 1'b0;
            esum_d   = '0;
            tick_d   = '0;
          end else begin
            pos_d = pos_q + {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
            if (active_q) begin
              if (tick_inc >= period_q) begin
                tick_d  = '0;
                state_d = StErr;
              end else begin
                tick_d = tick_inc;
              end
            end
          end
        end
      end
      StErr: begin
        err_d = err_sat;
        if ({16'd0, tol_q} > err_mag) begin
          done_d   = 1'b1;
          active_d = 1'b0;
          drive_d  = '0;
          state_d  = StResult;
        end else begin
          state_d = StInteg;
        end
      end
      StInteg: begin
        esum_d       = esum_sat;
        diff_d       = {err_q[31], err_q} - {last_q[31], last_q};
        sum_d        = '0;
        term_d       = 2'd0;
        idx_d        = 2'd0;
        mul_ctrl.clr = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        mul_ctrl.mul = 1'b1;
        state_d      = StAcc;
      end
      StAcc: begin
        mul_ctrl.acc = 1'b1;
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          state_d = StTerm;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = StMul;
        end
      end
      StTerm: begin
        sum_d        = sum_q + term_val;
        mul_ctrl.clr = 1'b1;
        if (term_q == 2'd2) begin
          state_d = StClamp;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = StMul;
        end
      end
      StClamp: begin
        if ($signed(sum_q) > 64'sd65536) begin
          drive_d = DrivePosOne;
        end else if ($signed(sum_q) < -64'sd65536) begin
          drive_d = DriveNegOne;
        end else begin
          drive_d = sum_q[DriveW-1:0];
        end
        last_d  = err_q;
        state_d = StResult;
      end
      StResult: begin
        out_valid_d = 1'b1;
        out_data_d  = {done_q, active_q, dir_val, cmp_val};
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      goal_q      <= '0;
      tick_q      <= '0;
      esum_q      <= '0;
      last_q      <= '0;
      drive_q     <= '0;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      term_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      goal_q      <= goal_d;
      tick_q      <= tick_d;
      esum_q      <= esum_d;
      last_q      <= last_d;
      drive_q     <= drive_d;
      active_q    <= active_d;
      done_q      <= done_d;
      term_q      <= term_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    diff_q     <= diff_d;
    sum_q      <= sum_d;
    out_data_q <= out_data_d;
  end

  // a result never lands on one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StResult |-> !out_valid_q)
    else $error("result register still occupied when a new result is ready");

  // every accepted item leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != StIdle)
    else $error("accepted item produced no work");

  // the drive stays within plus and minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(drive_q) <= 18'sd65536) && ($signed(drive_q) >= -18'sd65536))
    else $error("drive outside +-1.0");

  // a move is never running and finished at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(active_q && done_q))
    else $error("running and finished both set");

endmodule

>>> design/pmd_mul_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_mul_unit
// Shared 32x16 multiplier with an 80-bit accumulator; builds one saturated
// term magnitude a 16-bit digit of the second operand at a time
// ----------------------------------------------------------------------------
module pmd_mul_unit
  import pmd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmd_mul_ctrl_t       ctrl_i,
  input  logic [GainW-1:0]    a_mag_i,
  input  logic [SumW-1:0]     b_mag_i,
  output logic [TermMagW-1:0] sat_mag_o
);

  logic [ChunkW-1:0]       chunk;
  logic [GainW+ChunkW-1:0] prod_q, prod_d;
  logic [AccW-1:0]         acc_q, acc_d;
  logic [AccW-1:0]         prod_ext;
  logic [AccW-1:0]         prod_shift;

  always_comb begin
    case (ctrl_i.idx)
      2'd0:    chunk = b_mag_i[15:0];
      2'd1:    chunk = b_mag_i[31:16];
      2'd2:    chunk = b_mag_i[47:32];
      default: chunk = '0;
    endcase
  end

  assign prod_d   = ctrl_i.mul ? a_mag_i * chunk : prod_q;
  assign prod_ext = {{(AccW-GainW-ChunkW){1'b0}}, prod_q};

  always_comb begin
    case (ctrl_i.idx)
      2'd0:    prod_shift = prod_ext;
      2'd1:    prod_shift = {prod_ext[AccW-17:0], 16'd0};
      2'd2:    prod_shift = {prod_ext[AccW-33:0], 32'd0};
      default: prod_shift = '0;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      acc_d = acc_q + prod_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prod_q <= '0;
    end else begin
      acc_q  <= acc_d;
      prod_q <= prod_d;
    end
  end

  // clip the magnitude at 2^60
  always_comb begin
    if ((acc_q[AccW-1:61] != '0) || (acc_q[60] && (acc_q[59:0] != '0))) begin
      sat_mag_o = TermLimit;
    end else begin
      sat_mag_o = acc_q[TermMagW-1:0];
    end
  end

endmodule

>>> design/pmd_pwm_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pwm_map
// Maps the q2.16 drive onto a sign-magnitude pwm compare value
// ----------------------------------------------------------------------------
module pmd_pwm_map
  import pmd_pkg::*;
#(
  parameter int unsigned FULL_SCALE = 100
) (
  input  logic [DriveW-1:0] drive_i,
  output logic [CmpW-1:0]   compare_o,
  output logic              direction_o
);

  localparam logic [15:0] FsVal = 16'(FULL_SCALE);

  logic [DriveW-2:0] mag;
  logic [32:0]       prod;
  logic [16:0]       m;

  assign mag  = drive_i[DriveW-1] ? 17'(-drive_i) : drive_i[DriveW-2:0];
  assign prod = 33'(mag) * 33'(FsVal);
  assign m    = prod[32:16];

  always_comb begin
    compare_o   = '0;
    direction_o = 1'b0;
    if (m != '0) begin
      if (!drive_i[DriveW-1]) begin
        compare_o   = FsVal[CmpW-1:0] - m[CmpW-1:0];
        direction_o = 1'b1;
      end else begin
        compare_o = m[CmpW-1:0];
      end
    end
  end

endmodule
